// ----- src/ipv6_text_address_parser_unit_assert.svh -----
`ifndef IPV6_TEXT_ADDRESS_PARSER_UNIT_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_UNIT_ASSERT_SVH

// Checked outside reset.
`define IPV6TAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IPV6TAP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/ipv6tap_pkg.sv -----
package ipv6tap_pkg;

    localparam int CHAR_W   = 8;
    localparam int GROUP_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int INDEX_W  = 3;
    localparam int HALF_W   = 64;
    localparam int STORED_GROUPS = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int OUT_DATA_W = 2 * HALF_W + COUNT_W;

    localparam logic [INDEX_W-1:0]  LAST_GROUP = 3'd7;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 16'hFFFF;
    localparam logic [CHAR_W-1:0]   SEP_RESET  = 8'd58;
    localparam logic [0:0]          REG_SEPARATOR = 1'b0;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic                   valid;
        logic                   success;
        logic [HALF_W-1:0]      addr_high;
        logic [HALF_W-1:0]      addr_low;
        logic [COUNT_W-1:0]     length;
    } result_t;

    function automatic hex_t hex_digit(input logic [CHAR_W-1:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

// ----- src/ipv6tap_parse_core.sv -----
module ipv6tap_parse_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_fire,
    input  logic [ipv6tap_pkg::CHAR_W-1:0]   in_char,
    input  logic                             in_start,
    input  logic [ipv6tap_pkg::CHAR_W-1:0]   separator,
    output ipv6tap_pkg::result_t             result
);

    logic [ipv6tap_pkg::GROUP_W-1:0] value_reg, value_next;
    logic                            overflow_reg, overflow_next;
    logic                            has_digit_reg, has_digit_next;
    logic [ipv6tap_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [ipv6tap_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                            active_reg, active_next;
    logic [ipv6tap_pkg::GROUP_W-1:0] groups_reg [0:ipv6tap_pkg::STORED_GROUPS-1];

    logic [ipv6tap_pkg::GROUP_W-1:0] cur_value;
    logic                            cur_overflow;
    logic                            cur_has_digit;
    logic [ipv6tap_pkg::INDEX_W-1:0] cur_index;
    logic [ipv6tap_pkg::COUNT_W-1:0] cur_count;
    logic [ipv6tap_pkg::COUNT_W-1:0] count_inc;
    logic                            cur_active;
    logic                            store_group;
    ipv6tap_pkg::hex_t               hex;

    assign hex = ipv6tap_pkg::hex_digit(in_char);

    always_comb begin
        cur_value     = in_start ? '0 : value_reg;
        cur_overflow  = in_start ? 1'b0 : overflow_reg;
        cur_has_digit = in_start ? 1'b0 : has_digit_reg;
        cur_index     = in_start ? '0 : index_reg;
        cur_count     = in_start ? '0 : count_reg;
        cur_active    = in_start | active_reg;
        count_inc     = (cur_count == ipv6tap_pkg::COUNT_MAX) ? cur_count
                                                              : cur_count + 1'b1;

        value_next     = value_reg;
        overflow_next  = overflow_reg;
        has_digit_next = has_digit_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        store_group    = 1'b0;

        result.valid     = 1'b0;
        result.success   = 1'b0;
        result.addr_high = {groups_reg[0], groups_reg[1], groups_reg[2], groups_reg[3]};
        result.addr_low  = {groups_reg[4], groups_reg[5], groups_reg[6], cur_value};
        result.length    = cur_count;

        if (in_fire && cur_active) begin
            value_next     = cur_value;
            overflow_next  = cur_overflow;
            has_digit_next = cur_has_digit;
            index_next     = cur_index;
            count_next     = cur_count;
            active_next    = 1'b1;
            if (hex.is_hex) begin
                overflow_next  = cur_overflow | (cur_value[15:12] != 4'd0);
                value_next     = {cur_value[11:0], hex.value};
                has_digit_next = 1'b1;
                count_next     = count_inc;
            end else if (!cur_has_digit || cur_overflow) begin
                result.valid = 1'b1;
                active_next  = 1'b0;
            end else if (cur_index == ipv6tap_pkg::LAST_GROUP) begin
                result.valid   = 1'b1;
                result.success = 1'b1;
                active_next    = 1'b0;
            end else if (in_char != separator) begin
                result.valid = 1'b1;
                active_next  = 1'b0;
            end else begin
                store_group    = 1'b1;
                count_next     = count_inc;
                index_next     = cur_index + 1'b1;
                value_next     = '0;
                overflow_next  = 1'b0;
                has_digit_next = 1'b0;
            end
        end

        if (!result.success) begin
            result.addr_high = '0;
            result.addr_low  = '0;
            result.length    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg     <= '0;
            overflow_reg  <= 1'b0;
            has_digit_reg <= 1'b0;
            index_reg     <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
        end else begin
            value_reg     <= value_next;
            overflow_reg  <= overflow_next;
            has_digit_reg <= has_digit_next;
            index_reg     <= index_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_group) begin
            groups_reg[cur_index] <= cur_value;
        end
    end

endmodule

// ----- src/ipv6_text_address_parser_unit.sv -----
// A parse result is registered in the output register, or in the skid stage while m_tvalid stalls.
// Throughput: one character per cycle while the skid stage is empty; the output register and a
// one-entry skid stage keep the input side moving while a result waits for m_tready.
// Reset: aresetn is synchronous and active low; it drops any parse in progress, empties the
// output stages and sets the separator back to a colon.
module ipv6_text_address_parser_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [7:0] char_code
    input  logic                                  s_tuser,   // [0] start_flag
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [63:0] address_high, [127:64] address_low, [143:128] consumed_length
    output logic [ipv6tap_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                  m_tuser,   // [0] success
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ipv6tap_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ipv6tap_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ipv6tap_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                  pready
);

    logic [ipv6tap_pkg::CHAR_W-1:0]     separator_reg;
    logic                               in_fire;
    ipv6tap_pkg::result_t               result;
    logic                               out_fire;

    logic                               m_valid_reg;
    logic                               m_success_reg;
    logic [ipv6tap_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic                               skid_valid_reg;
    logic                               skid_success_reg;
    logic [ipv6tap_pkg::OUT_DATA_W-1:0] skid_data_reg;
    logic [ipv6tap_pkg::OUT_DATA_W-1:0] result_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ipv6tap_pkg::REG_SEPARATOR)
                  ? {{(ipv6tap_pkg::APB_DATA_W-ipv6tap_pkg::CHAR_W){1'b0}}, separator_reg}
                  : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg <= ipv6tap_pkg::SEP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ipv6tap_pkg::REG_SEPARATOR) begin
            separator_reg <= pwdata[ipv6tap_pkg::CHAR_W-1:0];
        end
    end

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;

    ipv6tap_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_char   (s_tdata),
        .in_start  (s_tuser),
        .separator (separator_reg),
        .result    (result)
    );

    assign result_data = {result.length, result.addr_low, result.addr_high};
    assign out_fire    = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || out_fire) begin
            m_valid_reg <= result.valid;
        end else if (result.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                m_data_reg    <= skid_data_reg;
                m_success_reg <= skid_success_reg;
            end
        end else if (!m_valid_reg || out_fire) begin
            m_data_reg    <= result_data;
            m_success_reg <= result.success;
        end else begin
            skid_data_reg    <= result_data;
            skid_success_reg <= result.success;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_success_reg;

endmodule

// ----- src/ipv6tap_checker.sv -----
`include "ipv6_text_address_parser_unit_assert.svh"

module ipv6tap_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ipv6tap_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                                m_tuser
);

    // A failed parse carries an all-zero address and length.
    `IPV6TAP_ASSERT(a_fail_zero, m_tvalid && !m_tuser |-> m_tdata == '0, "failure result not zero")

    // Eight groups of at least one digit plus seven separators.
    `IPV6TAP_ASSERT(a_min_length, m_tvalid && m_tuser |-> m_tdata[143:128] >= 16'd15, "length too short")

    `IPV6TAP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    `IPV6TAP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind ipv6_text_address_parser_unit ipv6tap_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/ipv6_text_address_parser_unit_checker.sv -----
module ipv6_text_address_parser_unit_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [ipv6tap_pkg::CHAR_W-1:0]          s_tdata,
    input  logic                                    s_tuser,
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [ipv6tap_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                    m_tuser,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic                                    pready,
    input  logic [ipv6tap_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ipv6tap_pkg::APB_DATA_W-1:0]      pwdata,
    output int                                      fail_count,
    output int                                      pending_results,
    output int                                      results_seen,
    output int                                      addresses_seen
);

    typedef logic [ipv6tap_pkg::APB_ADDR_W-1:0] apb_addr_t;

    localparam apb_addr_t SEP_ADDR = apb_addr_t'(4 * ipv6tap_pkg::REG_SEPARATOR);

    typedef struct packed {
        logic                               success;
        logic [ipv6tap_pkg::HALF_W-1:0]     high;
        logic [ipv6tap_pkg::HALF_W-1:0]     low;
        logic [ipv6tap_pkg::COUNT_W-1:0]    length;
    } parse_result_t;

    logic [ipv6tap_pkg::CHAR_W-1:0]     separator;
    logic [ipv6tap_pkg::GROUP_W-1:0]    group_acc;
    logic                               group_ovf;
    logic                               group_digit;
    logic [ipv6tap_pkg::INDEX_W-1:0]    group_idx;
    logic [ipv6tap_pkg::GROUP_W-1:0]    groups [8];
    logic [ipv6tap_pkg::COUNT_W-1:0]    chars_taken;
    logic                               parsing;
    parse_result_t                      result_q [$];

    initial begin
        fail_count = 0;
        pending_results = 0;
        results_seen = 0;
        addresses_seen = 0;
    end

    function automatic logic [4:0] nibble_of(input logic [ipv6tap_pkg::CHAR_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'd0;
    endfunction

    task automatic clear_address();
        group_acc = '0;
        group_ovf = 1'b0;
        group_digit = 1'b0;
        group_idx = '0;
        chars_taken = '0;
        for (int i = 0; i < 8; i++) begin
            groups[i] = '0;
        end
    endtask

    task automatic bump_count();
        if (chars_taken != ipv6tap_pkg::COUNT_MAX) begin
            chars_taken = chars_taken + 1'b1;
        end
    endtask

    task automatic finish_address(input logic ok);
        parse_result_t r;
        r.success = ok;
        r.high = ok ? {groups[0], groups[1], groups[2], groups[3]} : '0;
        r.low = ok ? {groups[4], groups[5], groups[6], groups[7]} : '0;
        r.length = ok ? chars_taken : '0;
        result_q.push_back(r);
        parsing = 1'b0;
    endtask

    task automatic take_char(input logic [ipv6tap_pkg::CHAR_W-1:0] c, input logic start);
        logic [4:0] nib;
        if (start) begin
            clear_address();
            parsing = 1'b1;
        end
        if (!parsing) begin
            return;
        end
        nib = nibble_of(c);
        if (nib[4]) begin
            if (group_acc[ipv6tap_pkg::GROUP_W-1:ipv6tap_pkg::GROUP_W-4] != 4'd0) begin
                group_ovf = 1'b1;
            end
            group_acc = {group_acc[ipv6tap_pkg::GROUP_W-5:0], nib[3:0]};
            group_digit = 1'b1;
            bump_count();
            return;
        end
        if (!group_digit || group_ovf) begin
            finish_address(1'b0);
            return;
        end
        groups[group_idx] = group_acc;
        if (group_idx == ipv6tap_pkg::LAST_GROUP) begin
            finish_address(1'b1);
            return;
        end
        if (c != separator) begin
            finish_address(1'b0);
            return;
        end
        bump_count();
        group_idx = group_idx + 1'b1;
        group_acc = '0;
        group_ovf = 1'b0;
        group_digit = 1'b0;
    endtask

    task automatic compare_result(input parse_result_t got);
        parse_result_t want;
        if (result_q.size() == 0) begin
            $error("unexpected result: success %0b, address %h_%h, consumed_length %0d",
                   got.success, got.high, got.low, got.length);
            fail_count++;
            return;
        end
        want = result_q.pop_front();
        results_seen++;
        if (want.success) begin
            addresses_seen++;
        end
        if (got.success !== want.success) begin
            $error("success: expected %0b, got %0b", want.success, got.success);
            fail_count++;
        end
        if (got.high !== want.high) begin
            $error("address_high: expected %h, got %h", want.high, got.high);
            fail_count++;
        end
        if (got.low !== want.low) begin
            $error("address_low: expected %h, got %h", want.low, got.low);
            fail_count++;
        end
        if (got.length !== want.length) begin
            $error("consumed_length: expected %0d, got %0d", want.length, got.length);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            separator = ipv6tap_pkg::SEP_RESET;
            clear_address();
            parsing = 1'b0;
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == SEP_ADDR) begin
                separator = pwdata[ipv6tap_pkg::CHAR_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                compare_result({m_tuser,
                                m_tdata[ipv6tap_pkg::HALF_W-1:0],
                                m_tdata[2*ipv6tap_pkg::HALF_W-1:ipv6tap_pkg::HALF_W],
                                m_tdata[ipv6tap_pkg::OUT_DATA_W-1:2*ipv6tap_pkg::HALF_W]});
            end
            if (s_tvalid && s_tready) begin
                take_char(s_tdata, s_tuser);
            end
        end
        pending_results <= result_q.size();
    end

endmodule

// ----- tb/ipv6_text_address_parser_unit_tb.sv -----
module ipv6_text_address_parser_unit_tb;

    typedef logic [ipv6tap_pkg::APB_ADDR_W-1:0] apb_addr_t;
    typedef logic [ipv6tap_pkg::APB_DATA_W-1:0] apb_data_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES = 200;
    localparam apb_addr_t SEP_ADDR = apb_addr_t'(4 * ipv6tap_pkg::REG_SEPARATOR);

    typedef enum int {
        FAULT_NONE,
        FAULT_CORRUPT,
        FAULT_EMPTY,
        FAULT_OVERFLOW,
        FAULT_SEPARATOR,
        FAULT_TRUNCATE
    } fault_t;

    logic                                   aclk = 1'b0;
    logic                                   aresetn;
    logic                                   s_tvalid;
    logic                                   s_tready;
    logic [ipv6tap_pkg::CHAR_W-1:0]         s_tdata;   // [7:0] char_code
    logic                                   s_tuser;   // [0] start_flag
    logic                                   m_tvalid;
    logic                                   m_tready;
    // [63:0] address_high, [127:64] address_low, [143:128] consumed_length
    logic [ipv6tap_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                                   m_tuser;   // [0] success
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    apb_addr_t                              paddr;
    apb_data_t                              pwdata;
    apb_data_t                              prdata;
    logic                                   pready;

    int                     fail_count;
    int                     pending_results;
    int                     results_seen;
    int                     addresses_seen;

    int                     tx_idle_pct;
    int                     rx_stall_pct;
    logic                   hold_go;
    int                     idle_cycles = 0;
    int                     chars_sent;
    logic [ipv6tap_pkg::CHAR_W-1:0] sep_now;
    logic [8:0]             text_q [$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ipv6_text_address_parser_unit uut (.*);

    ipv6_text_address_parser_unit_checker address_check (.*);

    // Stall the result side at random, and on hold_go hold it off so that requests back up into the input.
    initial begin
        m_tready = 1'b0;
        hold_go = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go <= 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_hex_char(c));
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(1) == 0 ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    task automatic push_char(input logic [7:0] c);
        logic first;
        first = (text_q.size() == 0);
        text_q.push_back({first, c});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endtask

    task automatic add_group(input int ndig, input bit lead_nonzero);
        for (int i = 0; i < ndig; i++) begin
            if (i == 0 && lead_nonzero) begin
                push_char(hex_char(4'($urandom_range(15, 1))));
            end else if (i < ndig - 4) begin
                push_char(8'h30);
            end else begin
                push_char(hex_char(4'($urandom_range(15))));
            end
        end
    endtask

    task automatic build_address(input fault_t fault);
        int fg;
        int pos;
        logic [7:0] c;
        fg = $urandom_range(7);
        for (int g = 0; g < 8; g++) begin
            if (g > 0) begin
                if (fault == FAULT_SEPARATOR && g == fg) begin
                    do begin
                        c = non_hex_char();
                    end while (c == sep_now);
                    push_char(c);
                end else begin
                    push_char(sep_now);
                end
            end
            if (fault == FAULT_EMPTY && g == fg) begin
                add_group(0, 1'b0);
            end else if (fault == FAULT_OVERFLOW && g == fg) begin
                add_group($urandom_range(7, 5), 1'b1);
            end else if ($urandom_range(9) == 0) begin
                add_group($urandom_range(6, 5), 1'b0);
            end else begin
                add_group($urandom_range(4, 1), 1'b0);
            end
        end
        if (fault == FAULT_TRUNCATE) begin
            pos = $urandom_range(text_q.size() - 1, 1);
            while (text_q.size() > pos) begin
                void'(text_q.pop_back());
            end
        end else if ($urandom_range(3) != 0) begin
            push_char(non_hex_char());
        end
        if (fault == FAULT_CORRUPT) begin
            pos = $urandom_range(text_q.size() - 1);
            text_q[pos][7:0] = 8'($urandom_range(255));
        end
    endtask

    task automatic offer(input logic [7:0] c, input logic start);
        s_tdata <= c;
        s_tuser <= start;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_text(input bit counted);
        logic [8:0] item;
        while (text_q.size() != 0) begin
            item = text_q.pop_front();
            offer(item[7:0], item[8]);
            if (counted) begin
                chars_sent++;
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SEP_ADDR;
        pwdata <= apb_data_t'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sep_now = v;
    endtask

    task automatic random_string();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            build_address(FAULT_NONE);
            send_text(1'b1);
        end else if (r < 80) begin
            build_address(fault_t'($urandom_range(5, 1)));
            send_text(1'b1);
        end else begin
            repeat ($urandom_range(8, 1)) begin
                text_q.push_back({($urandom_range(9) == 0), 8'($urandom_range(255))});
            end
            send_text(1'b0);
        end
    endtask

    function automatic logic [7:0] phase_separator(input int p);
        case (p)
            0: return ipv6tap_pkg::SEP_RESET;
            1: return 8'h00;
            2: return 8'hFF;
            3: return 8'h2E;
            4: return 8'h61;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int phase_base;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        sep_now = ipv6tap_pkg::SEP_RESET;
        chars_sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        add_text("0:0:0:0:0:0:0:0 ");
        send_text(1'b1);
        add_text("ffff:FFFF:ffff:FFFF:fFfF:FfFf:ABCD:9876");
        push_char(8'h00);
        send_text(1'b1);
        add_text("1:2:3:4:5:6:7:8");
        push_char(8'hFF);
        send_text(1'b1);
        text_q.push_back({1'b0, 8'h71});
        text_q.push_back({1'b0, 8'h35});
        send_text(1'b0);
        add_text("12:34");
        send_text(1'b1);
        add_text("0001:2:3:4:5:6:7:00000008.");
        send_text(1'b1);
        add_text("1::2:3:4:5:6:7:8 ");
        send_text(1'b1);
        add_text("12345:1:2:3:4:5:6:7 ");
        send_text(1'b1);
        add_text("1.2.3.4.5.6.7.8 ");
        send_text(1'b1);
        add_text("g");
        send_text(1'b1);
        add_text("1:2:3:4:5:6:7: ");
        send_text(1'b1);
        add_text("a:b:c:d:E:F:0:9:");
        send_text(1'b1);
        settle();
        write_separator(8'h61);
        add_text("1a2a3a4a5a6a7a8 ");
        send_text(1'b1);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_separator(phase_separator(p));
            tx_idle_pct = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 6 : 0;
            rx_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 6 : 0;
            if (p == 0) begin
                hold_go <= 1'b1;
                repeat (12) offer(8'h67, 1'b1);
            end
            phase_base = chars_sent;
            while (chars_sent - phase_base < ITEMS_PER_PHASE) begin
                random_string();
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        $display("Sent %0d address characters over %0d separator settings and four idle patterns.",
                 chars_sent, PHASES + 2);
        $display("Checked %0d results, %0d of them parsed addresses.",
                 results_seen, addresses_seen);
        if (fail_count == 0 && pending_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/ipv6tap_pkg.sv
src/ipv6tap_parse_core.sv
src/ipv6_text_address_parser_unit.sv
src/ipv6tap_checker.sv
tb/ipv6_text_address_parser_unit_checker.sv
tb/ipv6_text_address_parser_unit_tb.sv
